>>> design/hgg_pkg.sv
// ---------------------------------------------------------------------------
// Hex grid growth step package
// Shared types and constants for the hex-grid crystal growth update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hgg_pkg;

  // Growth rule codes.
  localparam logic [1:0] RULE_EXACT_ONE = 2'd0;
  localparam logic [1:0] RULE_EXACT_TWO = 2'd1;
  localparam logic [1:0] RULE_ANY       = 2'd2;
  localparam logic [1:0] RULE_RESET     = RULE_ANY;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // One result item.
  typedef struct packed {
    logic row_done;
    logic new_cell;
  } result_t;

endpackage

`default_nettype wire

>>> design/hex_grid_growth_step_top.sv
// ---------------------------------------------------------------------------
// Hex grid growth step
// One generation of a hex-grid crystal growth automaton, one column a cycle unless stalled.
// ---------------------------------------------------------------------------
// The block takes one column of three old cells (above, current, below) per
// request and can accept a new column in every cycle while at least two
// queue slots are free. The result for a cell comes out one column later.
// The last column of a row produces two results, so a row of N columns
// yields N results from N requests. Results go through a four-entry output
// queue, so the sustained rate is one column per cycle as long as the output
// side takes one result per cycle; the queue absorbs an output stall until
// fewer than two slots are free, and then the block holds off its input.
`timescale 1ns / 1ps
`default_nettype none

module hex_grid_growth_step_top
  import hgg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Configuration: growth rule register.
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  // Input column stream.
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,  // [0] above_cell, [1] center_cell, [2] below_cell
  input  wire logic [1:0] s_tuser,  // [0] row_is_odd, [1] row_is_border
  input  wire logic       s_tlast,  // row_end
  // Output cell stream.
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,  // [0] new_cell
  output logic            m_tlast   // row_done
);

  // Configuration and window state.
  logic [1:0] growth_rule;
  logic [1:0] window_above;
  logic [1:0] window_center;
  logic [1:0] window_below;
  logic [1:0] columns_seen;

  // Result queue.
  result_t           queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] queue_count;
  logic [QCNT_W-1:0] queue_count_next;

  // Decoded request.
  logic       in_fire;
  logic       out_fire;
  logic       cell_a;
  logic       cell_c;
  logic       cell_b;
  logic       row_odd;
  logic       row_border;
  logic [2:0] neighbor_count;
  logic       hit;
  logic       interior_val;
  logic       first_valid;
  result_t    first_res;
  result_t    last_res;
  result_t    entry0;
  logic [1:0] push_count;

  assign in_fire    = s_tvalid && s_tready;
  assign out_fire   = m_tvalid && m_tready;
  assign cell_a     = s_tdata[0];
  assign cell_c     = s_tdata[1];
  assign cell_b     = s_tdata[2];
  assign row_odd    = s_tuser[0];
  assign row_border = s_tuser[1];

  // Growth rule register.
  always_ff @(posedge clk) begin
    if (rst) begin
      growth_rule <= RULE_RESET;
    end else if (cfg_we) begin
      growth_rule <= cfg_wdata;
    end
  end

  // Count the six hex neighbors of the window's middle cell. The diagonals
  // lie to the right on odd rows and to the left on even rows.
  always_comb begin
    neighbor_count = 3'(window_center[1]) + 3'(cell_c)
                   + 3'(window_above[0]) + 3'(window_below[0]);
    if (row_odd) begin
      neighbor_count = neighbor_count + 3'(cell_a) + 3'(cell_b);
    end else begin
      neighbor_count = neighbor_count + 3'(window_above[1]) + 3'(window_below[1]);
    end
  end

  // Apply the growth rule; the unused code means no growth.
  always_comb begin
    case (growth_rule)
      RULE_EXACT_ONE: hit = (neighbor_count == 3'd1);
      RULE_EXACT_TWO: hit = (neighbor_count == 3'd2);
      RULE_ANY:       hit = (neighbor_count != 3'd0);
      default:        hit = 1'b0;
    endcase
  end

  // Results caused by this request: the middle cell once a column is held,
  // and the last column itself at the end of the row.
  always_comb begin
    interior_val       = window_center[0] | hit;
    first_valid        = (columns_seen != 2'd0);
    first_res.row_done = 1'b0;
    if (columns_seen == 2'd1 || row_border) begin
      first_res.new_cell = window_center[0];
    end else begin
      first_res.new_cell = interior_val;
    end
    last_res.new_cell = cell_c;
    last_res.row_done = 1'b1;
    entry0            = first_valid ? first_res : last_res;
    push_count        = 2'(first_valid) + 2'(s_tlast);
  end

  // Window shift, cleared at the end of each row.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_above  <= '0;
      window_center <= '0;
      window_below  <= '0;
      columns_seen  <= '0;
    end else if (in_fire) begin
      if (s_tlast) begin
        window_above  <= '0;
        window_center <= '0;
        window_below  <= '0;
        columns_seen  <= '0;
      end else begin
        window_above  <= {window_above[0], cell_a};
        window_center <= {window_center[0], cell_c};
        window_below  <= {window_below[0], cell_b};
        if (columns_seen != 2'd2) begin
          columns_seen <= columns_seen + 2'd1;
        end
      end
    end
  end

  // Queue storage: up to two entries written per request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (push_count != 2'd0) begin
        queue[wr_ptr] <= entry0;
      end
      if (push_count == 2'd2) begin
        queue[wr_ptr + QPTR_W'(1)] <= last_res;
      end
    end
  end

  // Queue occupancy.
  always_comb begin
    queue_count_next = queue_count;
    if (in_fire) begin
      queue_count_next = queue_count_next + QCNT_W'(push_count);
    end
    if (out_fire) begin
      queue_count_next = queue_count_next - QCNT_W'(1);
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      queue_count <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + QPTR_W'(push_count);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      queue_count <= queue_count_next;
    end
  end

  // Ports.
  assign s_tready = (queue_count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign m_tvalid = (queue_count != '0);
  assign m_tdata  = {7'd0, queue[rd_ptr].new_cell};
  assign m_tlast  = queue[rd_ptr].row_done;

endmodule

`default_nettype wire

>>> design/hgg_checker.sv
// ---------------------------------------------------------------------------
// Hex grid growth step checker
// Port-level assertions for the growth step block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgg_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // The end of a row always leaves at least one result pending.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("row end produced no result");

  // The input is only held off while results are waiting.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> m_tvalid)
    else $error("input stalled with empty output queue");

  // Results carry only the new cell bit.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("padding bits set in result");

endmodule

bind hex_grid_growth_step_top hgg_checker u_hgg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
